// ===== design/clcc_pkg.sv =====
`default_nettype none

package clcc_pkg;

	// Default width of one display row, in character cells.
	localparam int ROW_COLUMNS_DEF = 16;

	// Display-memory start addresses of the two rows.
	localparam logic [6:0] ROW0_BASE = 7'h00;
	localparam logic [6:0] ROW1_BASE = 7'h40;

	// Character codes with a cursor-movement meaning.
	localparam logic [7:0] CHR_TAB   = 8'h09;
	localparam logic [7:0] CHR_LF    = 8'h0A;
	localparam logic [7:0] CHR_VT    = 8'h0B;
	localparam logic [7:0] CHR_FF    = 8'h0C;
	localparam logic [7:0] CHR_CR    = 8'h0D;
	localparam logic [7:0] CHR_SPACE = 8'h20;

	// LCD command kinds.
	typedef enum logic [1:0] {
		KIND_PLACE = 2'd0,
		KIND_WRITE = 2'd1,
		KIND_HOME  = 2'd2
	} cmd_kind_t;

	// Source of the command value presented by the datapath.
	typedef enum logic [2:0] {
		VAL_SPACE,
		VAL_OTHER_ROW,
		VAL_TAB,
		VAL_ZERO,
		VAL_BASE,
		VAL_CODE
	} val_sel_t;

	// Controller sequence states.
	typedef enum logic [2:0] {
		S_IDLE,
		S_PAD,
		S_ROW,
		S_TAB,
		S_HOME,
		S_CR,
		S_WRAP,
		S_WRITE
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic     load;
		val_sel_t sel;
		logic     advance;
		logic     rebase;
		logic     commit;
	} ctl_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic cur_full;
		logic pad_last;
	} sts_t;

endpackage

`default_nettype wire

// ===== design/clcc_dpath.sv =====
`default_nettype none

module clcc_dpath #(
	parameter int ROW_COLUMNS = clcc_pkg::ROW_COLUMNS_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic [7:0]    char_code,
	input  wire clcc_pkg::ctl_t ctl,
	output clcc_pkg::sts_t     sts,
	output logic [7:0]         cmd_value
);

	logic [6:0] cursor_q;
	logic [7:0] work_q;
	logic [7:0] code_q;
	logic       row_q;

	logic [7:0] cur_limit;
	logic [7:0] row_limit;
	logic [6:0] row_base;
	logic [7:0] work_inc;
	logic [6:0] tab_addr;
	logic [6:0] other_row;
	logic [6:0] next_cursor;

	// Row limits: row start plus the row width, eight bits wide so that a
	// full-width second row reaches 128 without overflow.
	assign cur_limit = {1'b0, cursor_q[6], 6'b0} + 8'(ROW_COLUMNS);
	assign row_limit = {1'b0, row_q, 6'b0} + 8'(ROW_COLUMNS);
	assign row_base  = row_q ? clcc_pkg::ROW1_BASE : clcc_pkg::ROW0_BASE;
	assign work_inc  = work_q + 8'd1;

	// Tab target wraps to the row start once it reaches the row end.
	assign tab_addr  = ({1'b0, work_inc[6:0]} >= row_limit) ? row_base : work_inc[6:0];
	assign other_row = work_q[6] ? clcc_pkg::ROW0_BASE : clcc_pkg::ROW1_BASE;

	assign sts.cur_full = {1'b0, cursor_q} >= cur_limit;
	assign sts.pad_last = work_inc >= row_limit;

	// Command value and the cursor that the final command leaves behind.
	always_comb begin
		cmd_value   = 8'h00;
		next_cursor = clcc_pkg::ROW0_BASE;
		unique case (ctl.sel)
			clcc_pkg::VAL_SPACE: begin
				cmd_value   = clcc_pkg::CHR_SPACE;
				next_cursor = work_inc[6:0];
			end
			clcc_pkg::VAL_OTHER_ROW: begin
				cmd_value   = {1'b0, other_row};
				next_cursor = other_row;
			end
			clcc_pkg::VAL_TAB: begin
				cmd_value   = {1'b0, tab_addr};
				next_cursor = tab_addr;
			end
			clcc_pkg::VAL_ZERO: begin
				cmd_value   = 8'h00;
				next_cursor = clcc_pkg::ROW0_BASE;
			end
			clcc_pkg::VAL_BASE: begin
				cmd_value   = {1'b0, row_base};
				next_cursor = row_base;
			end
			clcc_pkg::VAL_CODE: begin
				cmd_value   = code_q;
				next_cursor = work_inc[6:0];
			end
			default: begin
				cmd_value   = 8'h00;
				next_cursor = clcc_pkg::ROW0_BASE;
			end
		endcase
	end

	// Cursor address, the only state kept between words.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q <= clcc_pkg::ROW0_BASE;
		end else if (ctl.commit) begin
			cursor_q <= next_cursor;
		end
	end

	// Working copy of the address and the latched character.
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			code_q <= char_code;
			work_q <= {1'b0, cursor_q};
			row_q  <= cursor_q[6];
		end else if (ctl.advance) begin
			work_q <= work_inc;
		end else if (ctl.rebase) begin
			work_q <= {1'b0, row_base};
		end
	end

	// Form feed always leaves the cursor at home.
	a_home_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.commit && ctl.sel == clcc_pkg::VAL_ZERO) |=> (cursor_q == clcc_pkg::ROW0_BASE))
		else $error("cursor not at home after form feed");

endmodule

`default_nettype wire

// ===== design/clcc_ctrl.sv =====
`default_nettype none

module clcc_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic [7:0]    char_code,
	input  wire logic          in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  wire logic          out_ready,
	output logic [1:0]         cmd_kind,
	output logic               last_cmd,
	input  wire clcc_pkg::sts_t sts,
	output clcc_pkg::ctl_t     ctl
);

	clcc_pkg::state_t state_q;
	clcc_pkg::state_t state_d;
	logic             out_acc;

	assign out_acc = out_valid && out_ready;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= clcc_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state, handshake and datapath commands. Input is ready only when
	// idle and a command is offered in every other state, so the handshake
	// terms reduce to the other side's signal.
	always_comb begin
		state_d     = state_q;
		in_ready    = 1'b0;
		out_valid   = 1'b1;
		cmd_kind    = clcc_pkg::KIND_PLACE;
		last_cmd    = 1'b1;
		ctl.load    = 1'b0;
		ctl.sel     = clcc_pkg::VAL_ZERO;
		ctl.advance = 1'b0;
		ctl.rebase  = 1'b0;
		ctl.commit  = 1'b0;
		unique case (state_q)
			clcc_pkg::S_IDLE: begin
				in_ready  = 1'b1;
				out_valid = 1'b0;
				last_cmd  = 1'b0;
				ctl.load  = in_valid;
				if (in_valid) begin
					priority if (char_code == clcc_pkg::CHR_TAB) begin
						state_d = clcc_pkg::S_TAB;
					end else if (char_code == clcc_pkg::CHR_LF) begin
						state_d = sts.cur_full ? clcc_pkg::S_ROW : clcc_pkg::S_PAD;
					end else if (char_code == clcc_pkg::CHR_VT) begin
						state_d = clcc_pkg::S_ROW;
					end else if (char_code == clcc_pkg::CHR_FF) begin
						state_d = clcc_pkg::S_HOME;
					end else if (char_code == clcc_pkg::CHR_CR) begin
						state_d = clcc_pkg::S_CR;
					end else begin
						state_d = sts.cur_full ? clcc_pkg::S_WRAP : clcc_pkg::S_WRITE;
					end
				end
			end
			clcc_pkg::S_PAD: begin
				cmd_kind    = clcc_pkg::KIND_WRITE;
				last_cmd    = 1'b0;
				ctl.sel     = clcc_pkg::VAL_SPACE;
				ctl.advance = out_ready;
				if (out_ready && sts.pad_last) begin
					state_d = clcc_pkg::S_ROW;
				end
			end
			clcc_pkg::S_ROW: begin
				ctl.sel    = clcc_pkg::VAL_OTHER_ROW;
				ctl.commit = out_ready;
				if (out_ready) begin
					state_d = clcc_pkg::S_IDLE;
				end
			end
			clcc_pkg::S_TAB: begin
				ctl.sel    = clcc_pkg::VAL_TAB;
				ctl.commit = out_ready;
				if (out_ready) begin
					state_d = clcc_pkg::S_IDLE;
				end
			end
			clcc_pkg::S_HOME: begin
				cmd_kind   = clcc_pkg::KIND_HOME;
				ctl.sel    = clcc_pkg::VAL_ZERO;
				ctl.commit = out_ready;
				if (out_ready) begin
					state_d = clcc_pkg::S_IDLE;
				end
			end
			clcc_pkg::S_CR: begin
				ctl.sel    = clcc_pkg::VAL_BASE;
				ctl.commit = out_ready;
				if (out_ready) begin
					state_d = clcc_pkg::S_IDLE;
				end
			end
			clcc_pkg::S_WRAP: begin
				last_cmd   = 1'b0;
				ctl.sel    = clcc_pkg::VAL_BASE;
				ctl.rebase = out_ready;
				if (out_ready) begin
					state_d = clcc_pkg::S_WRITE;
				end
			end
			clcc_pkg::S_WRITE: begin
				cmd_kind   = clcc_pkg::KIND_WRITE;
				ctl.sel    = clcc_pkg::VAL_CODE;
				ctl.commit = out_ready;
				if (out_ready) begin
					state_d = clcc_pkg::S_IDLE;
				end
			end
			default: begin
				state_d   = clcc_pkg::S_IDLE;
				out_valid = 1'b0;
			end
		endcase
	end

	// A new character is never taken while a command is being offered.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input taken while a command is pending");

	// The cursor is updated only together with the final command.
	a_commit_last: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.commit |-> (last_cmd && out_acc))
		else $error("cursor committed before the final command");

	// Accepting the final command always returns the sequencer to idle.
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_acc && last_cmd) |=> (state_q == clcc_pkg::S_IDLE))
		else $error("sequencer busy after the final command");

endmodule

`default_nettype wire

// ===== design/char_lcd_cursor_controller.sv =====
`default_nettype none

// Channel  | Direction | Handshake            | Word
// input    | in        | in_valid / in_ready  | char_code
// command  | out       | out_valid / out_ready| cmd_kind, cmd_value, last_cmd
//
// One character is taken at a time: a word is accepted only while no command
// is pending. Each command is held until it is accepted; a character causes up
// to ROW_COLUMNS + 1 commands, for a newline at the row start. Reset puts the
// cursor at address 0 and the sequencer idle. A stall on the command side
// holds the current command and keeps the input side waiting.

module char_lcd_cursor_controller #(
	parameter int ROW_COLUMNS = clcc_pkg::ROW_COLUMNS_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic [7:0] char_code,
	input  wire logic       in_valid,
	output logic            in_ready,
	output logic [1:0]      cmd_kind,
	output logic [7:0]      cmd_value,
	output logic            last_cmd,
	output logic            out_valid,
	input  wire logic       out_ready
);

	clcc_pkg::ctl_t ctl;
	clcc_pkg::sts_t sts;

	// Command sequencer.
	clcc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.char_code (char_code),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd_kind  (cmd_kind),
		.last_cmd  (last_cmd),
		.sts       (sts),
		.ctl       (ctl)
	);

	// Cursor and address datapath.
	clcc_dpath #(
		.ROW_COLUMNS (ROW_COLUMNS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.char_code (char_code),
		.ctl       (ctl),
		.sts       (sts),
		.cmd_value (cmd_value)
	);

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

	localparam int COLS        = clcc_pkg::ROW_COLUMNS_DEF;
	localparam int TAIL_CYCLES = COLS + 4;
	localparam int RANDOM_WORDS = 100;

	// One LCD command as the block should present it.
	typedef struct packed {
		clcc_pkg::cmd_kind_t kind;
		logic [7:0]          value;
		logic                last;
	} lcd_cmd_t;

	// Tracks the display cursor and queues the commands that each accepted
	// character should cause, then checks the block's commands against them.
	class cursor_cmd_tracker;
		logic [6:0] cursor;
		lcd_cmd_t   pending_cmds[$];
		int         errors;
		int         chars_seen;
		int         cmds_seen;
		int         row_wraps;
		int         full_pads;

		function new();
			cursor     = clcc_pkg::ROW0_BASE;
			errors     = 0;
			chars_seen = 0;
			cmds_seen  = 0;
			row_wraps  = 0;
			full_pads  = 0;
		endfunction

		function void add_cmd(clcc_pkg::cmd_kind_t kind, logic [7:0] value, logic last);
			lcd_cmd_t c;
			c.kind  = kind;
			c.value = value;
			c.last  = last;
			pending_cmds.push_back(c);
		endfunction

		// Works out the commands for one accepted character word.
		function void note_char(logic [7:0] code);
			logic [6:0] addr;
			logic [6:0] base;
			int         row_end;
			int         a;
			addr    = cursor;
			base    = (addr < clcc_pkg::ROW1_BASE) ? clcc_pkg::ROW0_BASE : clcc_pkg::ROW1_BASE;
			row_end = int'(base) + COLS;
			chars_seen++;
			case (code)
				clcc_pkg::CHR_TAB: begin
					addr = addr + 7'd1;
					if (int'(addr) >= row_end)
						addr = base;
					add_cmd(clcc_pkg::KIND_PLACE, {1'b0, addr}, 1'b1);
				end
				clcc_pkg::CHR_LF, clcc_pkg::CHR_VT: begin
					// A newline blanks the rest of the row before changing rows.
					if (code == clcc_pkg::CHR_LF) begin
						if (addr == base)
							full_pads++;
						a = int'(addr);
						while (a < row_end) begin
							add_cmd(clcc_pkg::KIND_WRITE, clcc_pkg::CHR_SPACE, 1'b0);
							a++;
						end
						addr = a[6:0];
					end
					addr = (addr < clcc_pkg::ROW1_BASE) ? clcc_pkg::ROW1_BASE
						: clcc_pkg::ROW0_BASE;
					add_cmd(clcc_pkg::KIND_PLACE, {1'b0, addr}, 1'b1);
				end
				clcc_pkg::CHR_FF: begin
					addr = clcc_pkg::ROW0_BASE;
					add_cmd(clcc_pkg::KIND_HOME, 8'h00, 1'b1);
				end
				clcc_pkg::CHR_CR: begin
					addr = base;
					add_cmd(clcc_pkg::KIND_PLACE, {1'b0, addr}, 1'b1);
				end
				default: begin
					// A full row wraps to its own start before the write.
					if (int'(addr) >= row_end) begin
						addr = base;
						add_cmd(clcc_pkg::KIND_PLACE, {1'b0, addr}, 1'b0);
						row_wraps++;
					end
					add_cmd(clcc_pkg::KIND_WRITE, code, 1'b1);
					addr = addr + 7'd1;
				end
			endcase
			cursor = addr;
		endfunction

		// Compares one accepted command word with the oldest expected one.
		function void check_cmd(logic [1:0] kind, logic [7:0] value, logic last);
			lcd_cmd_t want;
			cmds_seen++;
			if (pending_cmds.size() == 0) begin
				$error("unexpected command: cmd_kind %0d cmd_value 0x%h last_cmd %0d",
					kind, value, last);
				errors++;
				return;
			end
			want = pending_cmds.pop_front();
			if (kind !== want.kind) begin
				$error("cmd_kind: expected %0d, actual %0d", want.kind, kind);
				errors++;
			end
			if (value !== want.value) begin
				$error("cmd_value: expected 0x%h, actual 0x%h", want.value, value);
				errors++;
			end
			if (last !== want.last) begin
				$error("last_cmd: expected %0d, actual %0d", want.last, last);
				errors++;
			end
		endfunction

		function int pending();
			return pending_cmds.size();
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic [7:0] char_code;
	logic       in_valid;
	logic       in_ready;
	logic [1:0] cmd_kind;
	logic [7:0] cmd_value;
	logic       last_cmd;
	logic       out_valid;
	logic       out_ready = 1'b0;

	cursor_cmd_tracker tracker = new();

	int burst_left  = 0;
	int ready_mode  = 0;
	int mode_left   = 0;
	int random_sent = 0;

	logic [7:0] directed_chars [] = '{
		clcc_pkg::CHR_FF, 8'h00, 8'hFF, 8'h07, 8'h08, 8'h1B, clcc_pkg::CHR_TAB,
		clcc_pkg::CHR_CR, clcc_pkg::CHR_LF, clcc_pkg::CHR_VT, clcc_pkg::CHR_VT,
		clcc_pkg::CHR_LF, 8'h0E, 8'h1F, 8'h7F, 8'h80, clcc_pkg::CHR_TAB,
		clcc_pkg::CHR_CR, clcc_pkg::CHR_FF
	};

	char_lcd_cursor_controller dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.char_code (char_code),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.cmd_kind  (cmd_kind),
		.cmd_value (cmd_value),
		.last_cmd  (last_cmd),
		.out_valid (out_valid),
		.out_ready (out_ready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watch both channels and pass every accepted word to the tracker.
	always @(posedge clk) begin
		if (in_valid && in_ready)
			tracker.note_char(char_code);
		if (out_valid && out_ready)
			tracker.check_cmd(cmd_kind, cmd_value, last_cmd);
	end

	// The command side runs through spells of full speed, light and heavy stalls, and toggling.
	always @(posedge clk) begin
		if (mode_left == 0) begin
			ready_mode <= $urandom_range(0, 3);
			mode_left  <= $urandom_range(16, 80);
		end else begin
			mode_left <= mode_left - 1;
		end
		case (ready_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= ($urandom_range(0, 3) != 0);
			2: out_ready <= ($urandom_range(0, 3) == 0);
			default: out_ready <= ~out_ready;
		endcase
	end

	// Offers one character word and waits for it to be taken. Words go out in
	// bursts, with an occasional idle gap before a new burst.
	task automatic send_char(input logic [7:0] code);
		if (burst_left == 0) begin
			if ($urandom_range(0, 3) != 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
			burst_left = $urandom_range(1, 10);
		end
		burst_left--;
		in_valid  <= 1'b1;
		char_code <= code;
		do @(posedge clk); while (!in_ready);
	endtask

	// A line of text, sometimes longer than a row, ended by up to two tabs and a
	// cursor control code.
	task automatic send_line();
		int         len;
		logic [7:0] c;
		len = $urandom_range(0, COLS + 4);
		for (int k = 0; k < len; k++) begin
			if ($urandom_range(0, 4) != 0)
				c = 8'($urandom_range(8'h20, 8'h7E));
			else
				c = 8'($urandom_range(0, 255));
			send_char(c);
			random_sent++;
		end
		repeat ($urandom_range(0, 2)) begin
			send_char(clcc_pkg::CHR_TAB);
			random_sent++;
		end
		case ($urandom_range(0, 5))
			0, 1: send_char(clcc_pkg::CHR_LF);
			2: send_char(clcc_pkg::CHR_VT);
			3: send_char(clcc_pkg::CHR_FF);
			default: send_char(clcc_pkg::CHR_CR);
		endcase
		random_sent++;
	endtask

	initial begin
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		char_code <= 8'h00;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed words: byte extremes, escape-style codes and every control.
		foreach (directed_chars[i])
			send_char(directed_chars[i]);

		// Random text lines, with a little raw noise between them.
		while (random_sent < RANDOM_WORDS) begin
			if ($urandom_range(0, 9) == 0) begin
				send_char(8'($urandom_range(0, 255)));
				random_sent++;
			end else begin
				send_line();
			end
		end
		in_valid <= 1'b0;

		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Run covered %0d characters and %0d LCD commands,", tracker.chars_seen,
			tracker.cmds_seen);
		$display("including %0d row wraps and %0d full-row newlines.", tracker.row_wraps,
			tracker.full_pads);
		if (tracker.errors == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

	// Guard against a hung handshake.
	initial begin
		#2000000;
		$display("testbench failed");
		$finish;
	end

endmodule
